// ----- sv/ultrasonic_echo_ranger_macros.svh -----
// assertion macros for the ultrasonic echo ranger checker
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// clocked assertion, quiet while reset is high
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define UER_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/uer_pkg.sv -----
// types and constants shared by the ultrasonic echo ranger modules
`default_nettype none
package uer_pkg;

  localparam int unsigned TimerWidth = 16;
  localparam int unsigned PeriodWidth = 17;
  localparam int unsigned ProdWidth = 25;
  localparam int unsigned ScaledWidth = ProdWidth - 4;
  localparam int unsigned RecipWidth = 22;
  localparam int unsigned RecipShift = 28;
  localparam int unsigned DistWidth = 14;
  localparam int unsigned FullWidth = ScaledWidth + RecipWidth;

  localparam logic [ProdWidth-1:0] SoundFactor = ProdWidth'(343);
  localparam logic [ProdWidth-1:0] RoundOffset = ProdWidth'(1000);
  // ceil(2^28 / 125): exact quotient for every 21-bit dividend
  localparam logic [RecipWidth-1:0] Recip125 = RecipWidth'(2147484);
  localparam logic [DistWidth-1:0] MaxDistance = DistWidth'(11240);

  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(60000);
  localparam logic [TimerWidth-1:0] MinWidthReset = TimerWidth'(100);
  localparam logic [TimerWidth-1:0] MaxWidthReset = TimerWidth'(38000);

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_MIN_WIDTH = 2'd1,
    CFG_MAX_WIDTH = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_NO_ECHO = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef struct packed {
    logic period_start;
    logic rise_seen;
    logic [TimerWidth-1:0] rise_time;
    logic fall_seen;
    logic [TimerWidth-1:0] fall_time;
    logic timeout_hit;
    logic capture_overrun;
    logic [31:0] now_ms;
  } event_t;

  typedef struct packed {
    status_t status;
    logic [ProdWidth-1:0] prod;
    logic [31:0] seq;
    logic [31:0] stamp;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/uer_track.sv -----
// event decode, arm and rise tracking, echo width and bounds check
`default_nettype none
module uer_track (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire uer_pkg::event_t evt,
  input  wire logic [uer_pkg::PeriodWidth-1:0] echo_period_us,
  input  wire logic [uer_pkg::TimerWidth-1:0] min_width_us,
  input  wire logic [uer_pkg::TimerWidth-1:0] max_width_us,
  output logic hit,
  output uer_pkg::result_t res
);

  logic armed;
  logic armed_next;
  logic rise_held;
  logic rise_held_next;
  logic [uer_pkg::TimerWidth-1:0] held_rise_time;
  logic [uer_pkg::TimerWidth-1:0] held_rise_time_next;
  logic [31:0] sequence_count;
  logic [31:0] sequence_count_next;

  logic armed_eff;
  logic held_eff;
  logic rise_take;
  logic [uer_pkg::TimerWidth-1:0] rise_ref;
  logic [uer_pkg::TimerWidth-1:0] gap;
  logic [uer_pkg::PeriodWidth-1:0] width;
  logic possible;
  logic in_bounds;

  always_comb begin
    armed_eff = evt.period_start | armed;
    held_eff = ~evt.period_start & rise_held;
    rise_take = ~evt.capture_overrun & evt.rise_seen & armed_eff;
    rise_ref = rise_take ? evt.rise_time : held_rise_time;

    // a fall before the rise wraps once through the period; a gap above the period marks the pair impossible
    gap = rise_ref - evt.fall_time;
    possible = 1'b1;
    if (evt.fall_time >= rise_ref) begin
      width = {1'b0, evt.fall_time - rise_ref};
    end else begin
      possible = {1'b0, gap} <= echo_period_us;
      width = echo_period_us - {1'b0, gap};
    end
    in_bounds = possible && (width >= {1'b0, min_width_us}) &&
                (width <= {1'b0, max_width_us});

    hit = 1'b0;
    res.status = uer_pkg::ST_BAD;
    if (evt.capture_overrun) begin
      hit = 1'b1;
    end else if (evt.fall_seen && armed_eff && (rise_take || held_eff)) begin
      hit = 1'b1;
      res.status = in_bounds ? uer_pkg::ST_VALID : uer_pkg::ST_BAD;
    end else if (evt.timeout_hit && armed_eff) begin
      hit = 1'b1;
      res.status = uer_pkg::ST_NO_ECHO;
    end

    res.prod = uer_pkg::ProdWidth'(width[uer_pkg::TimerWidth-1:0]) * uer_pkg::SoundFactor
               + uer_pkg::RoundOffset;
    sequence_count_next = sequence_count + 32'(hit);
    res.seq = sequence_count_next;
    res.stamp = evt.now_ms;

    armed_next = hit ? 1'b0 : armed_eff;
    rise_held_next = rise_take | held_eff;
    held_rise_time_next = rise_ref;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b1;
      rise_held <= 1'b0;
      sequence_count <= '0;
    end else if (fire) begin
      armed <= armed_next;
      rise_held <= rise_held_next;
      sequence_count <= sequence_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_rise_time <= held_rise_time_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/uer_scale.sv -----
// divide the rounded width product by 2000 with a reciprocal multiply
`default_nettype none
module uer_scale (
  input  wire logic [uer_pkg::ProdWidth-1:0] prod,
  output logic [uer_pkg::DistWidth-1:0] mm
);

  logic [uer_pkg::ScaledWidth-1:0] scaled;
  logic [uer_pkg::FullWidth-1:0] full;

  always_comb begin
    // 2000 = 16 * 125: shift out the 16, then multiply by the 125 reciprocal
    scaled = prod[uer_pkg::ProdWidth-1:4];
    full = uer_pkg::FullWidth'(scaled) * uer_pkg::FullWidth'(uer_pkg::Recip125);
    mm = full[uer_pkg::RecipShift + uer_pkg::DistWidth - 1:uer_pkg::RecipShift];
  end

endmodule
`default_nettype wire

// ----- sv/ultrasonic_echo_ranger.sv -----
// ultrasonic echo ranger top level: config registers and item pipeline
`default_nettype none
// Takes one timer event snapshot per cycle and gives at most one range result
// for it. Three register stages: the snapshot register, where the event logic
// updates the arm and rise state and forms the width product; a scaling stage
// that turns the product into millimetres; and the result register. One
// snapshot can be accepted every cycle; each stage moves on as soon as the
// one after it is free, so a stalled result only holds back input once all
// stages are full. Snapshots that cause no result leave nothing in the later
// stages.
module ultrasonic_echo_ranger (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic period_start,
  input  wire logic rise_seen,
  input  wire logic [15:0] rise_time,
  input  wire logic fall_seen,
  input  wire logic [15:0] fall_time,
  input  wire logic timeout_hit,
  input  wire logic capture_overrun,
  input  wire logic [31:0] now_ms,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] result_status,
  output logic [13:0] result_mm,
  output logic [31:0] result_sequence,
  output logic [31:0] stamp_ms
);

  logic [uer_pkg::PeriodWidth-1:0] echo_period_us;
  logic [uer_pkg::TimerWidth-1:0] min_width_us;
  logic [uer_pkg::TimerWidth-1:0] max_width_us;

  logic s0_valid;
  uer_pkg::event_t s0_evt;
  logic s0_fire;
  logic s1_valid;
  uer_pkg::result_t s1_res;
  logic s1_fire;

  logic hit;
  uer_pkg::result_t res;
  logic [uer_pkg::DistWidth-1:0] mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_period_us <= uer_pkg::PeriodReset;
      min_width_us <= uer_pkg::MinWidthReset;
      max_width_us <= uer_pkg::MaxWidthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::CFG_PERIOD: echo_period_us <= cfg_data;
        uer_pkg::CFG_MIN_WIDTH: min_width_us <= cfg_data[uer_pkg::TimerWidth-1:0];
        uer_pkg::CFG_MAX_WIDTH: max_width_us <= cfg_data[uer_pkg::TimerWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_fire = s1_valid && (!out_valid || out_ready);
    s0_fire = s0_valid && (!s1_valid || s1_fire);
    in_ready = !s0_valid || s0_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (s0_fire) begin
        s1_valid <= hit;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_evt.period_start <= period_start;
      s0_evt.rise_seen <= rise_seen;
      s0_evt.rise_time <= rise_time;
      s0_evt.fall_seen <= fall_seen;
      s0_evt.fall_time <= fall_time;
      s0_evt.timeout_hit <= timeout_hit;
      s0_evt.capture_overrun <= capture_overrun;
      s0_evt.now_ms <= now_ms;
    end
    if (s0_fire) begin
      s1_res <= res;
    end
    if (s1_fire) begin
      result_status <= s1_res.status;
      result_mm <= (s1_res.status == uer_pkg::ST_VALID) ? mm : '0;
      result_sequence <= s1_res.seq;
      stamp_ms <= s1_res.stamp;
    end
  end

  uer_track u_track (
    .clk(clk),
    .rst(rst),
    .fire(s0_fire),
    .evt(s0_evt),
    .echo_period_us(echo_period_us),
    .min_width_us(min_width_us),
    .max_width_us(max_width_us),
    .hit(hit),
    .res(res)
  );

  uer_scale u_scale (
    .prod(s1_res.prod),
    .mm(mm)
  );

endmodule
`default_nettype wire

// ----- sv/uer_checker.sv -----
// port-level checker for the ultrasonic echo ranger and its bind
`default_nettype none
`include "ultrasonic_echo_ranger_macros.svh"
module uer_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] result_status,
  input wire logic [13:0] result_mm,
  input wire logic [31:0] result_sequence
);

  logic [31:0] last_seq;

  // sequence of the last item taken from the output
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq <= '0;
    end else if (out_valid && out_ready) begin
      last_seq <= result_sequence;
    end
  end

  `UER_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result shown right after reset")
  `UER_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(result_sequence), "stalled result changed")
  `UER_ASSERT(a_seq_step, out_valid |-> result_sequence == last_seq + 32'd1, "result sequence skipped or repeated")
  `UER_ASSERT(a_zero_dist, out_valid && result_status != uer_pkg::ST_VALID |-> result_mm == '0, "distance on a failed range")
  `UER_ASSERT(a_dist_max, out_valid && result_status == uer_pkg::ST_VALID |-> result_mm <= uer_pkg::MaxDistance, "distance beyond reach")

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .result_status(result_status),
  .result_mm(result_mm),
  .result_sequence(result_sequence)
);
`default_nettype wire

// ----- verif/tb.sv -----
// testbench for ultrasonic_echo_ranger: range scoreboard, snapshot stimulus and result checks
`timescale 1ns / 100ps
module tb;

  typedef struct packed {
    uer_pkg::status_t status;
    logic [13:0] mm;
    logic [31:0] seq;
    logic [31:0] stamp;
  } range_result_t;

  class range_scoreboard;
    bit armed;
    bit rise_held;
    logic [15:0] held_rise;
    logic [31:0] seq_count;
    logic [16:0] period;
    logic [15:0] min_w;
    logic [15:0] max_w;
    range_result_t pending_ranges[$];
    int errors;
    int n_ranged;
    int n_no_echo;
    int n_bad;

    function new();
      armed = 1'b1;
      rise_held = 1'b0;
      held_rise = '0;
      seq_count = '0;
      period = uer_pkg::PeriodReset;
      min_w = uer_pkg::MinWidthReset;
      max_w = uer_pkg::MaxWidthReset;
      errors = 0;
      n_ranged = 0;
      n_no_echo = 0;
      n_bad = 0;
    endfunction

    function void set_reg(uer_pkg::cfg_index_t idx, logic [16:0] val);
      case (idx)
        uer_pkg::CFG_PERIOD: period = val;
        uer_pkg::CFG_MIN_WIDTH: min_w = val[15:0];
        uer_pkg::CFG_MAX_WIDTH: max_w = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_ranges.size();
    endfunction

    // works out the range result, if any, of one accepted snapshot
    function void note_snapshot(uer_pkg::event_t s);
      range_result_t r;
      bit made;
      bit fits;
      int unsigned width;
      int unsigned gap;
      made = 1'b0;
      r = '0;
      if (s.period_start) begin
        armed = 1'b1;
        rise_held = 1'b0;
      end
      if (s.capture_overrun) begin
        made = 1'b1;
        r.status = uer_pkg::ST_BAD;
      end else begin
        if (s.rise_seen && armed) begin
          held_rise = s.rise_time;
          rise_held = 1'b1;
        end
        if (s.fall_seen && armed && rise_held) begin
          made = 1'b1;
          fits = 1'b1;
          if (s.fall_time >= held_rise) begin
            width = s.fall_time - held_rise;
          end else begin
            gap = held_rise - s.fall_time;
            // fall before rise wraps through the period unless the pair cannot exist
            if (gap > period) begin
              fits = 1'b0;
              width = 0;
            end else begin
              width = period - gap;
            end
          end
          if (fits && width >= min_w && width <= max_w) begin
            r.status = uer_pkg::ST_VALID;
            // half the round trip at 343 m/s, rounded
            r.mm = 14'((width * 343 + 1000) / 2000);
          end else begin
            r.status = uer_pkg::ST_BAD;
          end
        end else if (s.timeout_hit && armed) begin
          made = 1'b1;
          r.status = uer_pkg::ST_NO_ECHO;
        end
      end
      if (made) begin
        seq_count = seq_count + 1;
        armed = 1'b0;
        r.seq = seq_count;
        r.stamp = s.now_ms;
        pending_ranges.push_back(r);
      end
    endfunction

    function void check_result(logic [1:0] status, logic [13:0] mm, logic [31:0] seq,
                               logic [31:0] stamp);
      range_result_t want;
      if (pending_ranges.size() == 0) begin
        $error("range result with none pending: status %0d seq %0d", status, seq);
        errors++;
        return;
      end
      want = pending_ranges.pop_front();
      if (status !== want.status) begin
        $error("result_status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (mm !== want.mm) begin
        $error("result_mm: expected %0d, got %0d", want.mm, mm);
        errors++;
      end
      if (seq !== want.seq) begin
        $error("result_sequence: expected %0d, got %0d", want.seq, seq);
        errors++;
      end
      if (stamp !== want.stamp) begin
        $error("stamp_ms: expected %0h, got %0h", want.stamp, stamp);
        errors++;
      end
      case (want.status)
        uer_pkg::ST_VALID: n_ranged++;
        uer_pkg::ST_NO_ECHO: n_no_echo++;
        default: n_bad++;
      endcase
    endfunction
  endclass

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  uer_pkg::event_t snap_q = '0;
  logic out_ready = 1'b0;
  wire in_ready;
  wire out_valid;
  wire [1:0] result_status;
  wire [13:0] result_mm;
  wire [31:0] result_sequence;
  wire [31:0] stamp_ms;

  range_scoreboard sb;
  uer_pkg::event_t plan[$];
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  ultrasonic_echo_ranger dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .period_start(snap_q.period_start),
    .rise_seen(snap_q.rise_seen),
    .rise_time(snap_q.rise_time),
    .fall_seen(snap_q.fall_seen),
    .fall_time(snap_q.fall_time),
    .timeout_hit(snap_q.timeout_hit),
    .capture_overrun(snap_q.capture_overrun),
    .now_ms(snap_q.now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_status(result_status),
    .result_mm(result_mm),
    .result_sequence(result_sequence),
    .stamp_ms(stamp_ms)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_snapshot(snap_q);
      if (out_valid && out_ready)
        sb.check_result(result_status, result_mm, result_sequence, stamp_ms);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  function automatic uer_pkg::event_t quiet_snapshot();
    uer_pkg::event_t s;
    s = '0;
    s.rise_time = 16'($urandom);
    s.fall_time = 16'($urandom);
    s.now_ms = $urandom;
    return s;
  endfunction

  function automatic uer_pkg::event_t snap(bit st, bit rs, logic [15:0] rt, bit fs,
                                           logic [15:0] ft, bit to, bit ov,
                                           logic [31:0] now);
    uer_pkg::event_t s;
    s = '0;
    s.period_start = st;
    s.rise_seen = rs;
    s.rise_time = rt;
    s.fall_seen = fs;
    s.fall_time = ft;
    s.timeout_hit = to;
    s.capture_overrun = ov;
    s.now_ms = now;
    return s;
  endfunction

  function automatic uer_pkg::event_t noise_snapshot();
    uer_pkg::event_t s;
    s = quiet_snapshot();
    s.period_start = ($urandom_range(3) == 0);
    s.rise_seen = ($urandom_range(3) == 0);
    s.fall_seen = ($urandom_range(3) == 0);
    s.timeout_hit = ($urandom_range(3) == 0);
    s.capture_overrun = ($urandom_range(15) == 0);
    return s;
  endfunction

  // one start-rise-fall-timeout measurement with random content and bounds-hugging widths
  function automatic void plan_measurement();
    uer_pkg::event_t s;
    int unsigned lim;
    int unsigned rise_t;
    int unsigned fall_t;
    int target;
    int first;
    int k;
    bit rise_done;
    first = plan.size();
    lim = sb.period - 1;
    rise_t = $urandom_range(lim);
    case ($urandom_range(3))
      0: target = int'(sb.min_w) + int'($urandom_range(2)) - 1;
      1: target = int'(sb.max_w) + int'($urandom_range(2)) - 1;
      default: target = $urandom_range(lim);
    endcase
    if (target < 0) target = 0;
    fall_t = (rise_t + (int'(target) % sb.period)) % sb.period;
    // captures beyond the period now and then
    if ($urandom_range(9) == 0) begin
      rise_t = $urandom_range(65535);
      fall_t = $urandom_range(65535);
    end
    s = quiet_snapshot();
    s.period_start = 1'b1;
    rise_done = ($urandom_range(3) == 0);
    if (rise_done) begin
      s.rise_seen = 1'b1;
      s.rise_time = 16'(rise_t);
    end
    plan.push_back(s);
    repeat ($urandom_range(2)) plan.push_back(quiet_snapshot());
    s = quiet_snapshot();
    if (!rise_done) begin
      s.rise_seen = 1'b1;
      s.rise_time = 16'(rise_t);
      if ($urandom_range(4) != 0) begin
        plan.push_back(s);
        s = quiet_snapshot();
      end
    end
    s.fall_seen = ($urandom_range(9) != 0);
    s.fall_time = 16'(fall_t);
    s.timeout_hit = ($urandom_range(4) == 0);
    plan.push_back(s);
    if ($urandom_range(1) == 0) begin
      s = quiet_snapshot();
      s.timeout_hit = 1'b1;
      plan.push_back(s);
    end
    if ($urandom_range(11) == 0) begin
      k = $urandom_range(plan.size() - 1, first);
      s = plan[k];
      s.capture_overrun = 1'b1;
      plan[k] = s;
    end
  endfunction

  task automatic wait_for_results();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (sb.pending() == 0) break;
    end
    @(posedge clk);
  endtask

  task automatic send_snapshot(input uer_pkg::event_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    snap_q <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_plan();
    while (plan.size() != 0) begin
      if ($urandom_range(299) == 0) wait_for_results();
      send_snapshot(plan.pop_front());
    end
  endtask

  task automatic run_random(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      if ($urandom_range(7) == 0) begin
        plan.push_back(noise_snapshot());
      end else begin
        plan_measurement();
      end
      send_plan();
    end
  endtask

  task automatic put_reg(input uer_pkg::cfg_index_t idx, input logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // only with the pipe drained, including items that give no result
  task automatic configure(input logic [16:0] period, input logic [15:0] min_w,
                           input logic [15:0] max_w);
    wait_for_results();
    repeat (8) @(posedge clk);
    put_reg(uer_pkg::CFG_PERIOD, period);
    put_reg(uer_pkg::CFG_MIN_WIDTH, 17'(min_w));
    put_reg(uer_pkg::CFG_MAX_WIDTH, 17'(max_w));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned rp;
    int unsigned rmin;
    int unsigned rmax;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: armed out of reset, period 60000, widths 100..38000
    plan.push_back(snap(0, 1, 16'd0, 0, 16'd0, 0, 0, 32'd1));
    plan.push_back(snap(0, 0, 16'd5, 1, 16'd100, 1, 0, 32'd2));
    plan.push_back(snap(0, 0, 16'd0, 0, 16'd0, 1, 0, 32'd3));
    plan.push_back(snap(1, 0, 16'd0, 0, 16'd0, 1, 0, 32'hFFFF_FFFF));
    plan.push_back(snap(1, 1, 16'hFFFF, 0, 16'd0, 0, 0, 32'd5));
    plan.push_back(snap(0, 0, 16'd0, 1, 16'd0, 0, 0, 32'd6));
    plan.push_back(snap(1, 1, 16'd50000, 0, 16'd0, 0, 0, 32'd7));
    plan.push_back(snap(0, 0, 16'd0, 1, 16'd28000, 0, 0, 32'd8));
    plan.push_back(snap(1, 1, 16'd1000, 1, 16'd1099, 0, 0, 32'd9));
    plan.push_back(snap(1, 1, 16'd0, 0, 16'd0, 0, 0, 32'd10));
    plan.push_back(snap(0, 0, 16'd0, 1, 16'd38001, 0, 0, 32'd11));
    // overrun while disarmed, other flags along for the ride
    plan.push_back(snap(0, 1, 16'd123, 1, 16'd456, 1, 1, 32'd12));
    plan.push_back(snap(1, 0, 16'd0, 1, 16'd500, 0, 0, 32'd13));
    plan.push_back(snap(0, 0, 16'd0, 0, 16'd0, 1, 0, 32'd14));
    plan.push_back(snap(0, 1, 16'd200, 1, 16'd300, 0, 0, 32'd15));
    plan.push_back(snap(1, 1, 16'd777, 1, 16'd777, 0, 0, 32'd16));
    plan.push_back(snap(1, 1, 16'd59999, 1, 16'd37999, 0, 0, 32'd17));
    plan.push_back(snap(0, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0, 32'd0));
    plan.push_back(snap(1, 0, 16'd0, 0, 16'd0, 0, 1, 32'h5A5A_5A5A));
    // second rise replaces the first
    plan.push_back(snap(1, 1, 16'd100, 0, 16'd0, 0, 0, 32'd20));
    plan.push_back(snap(0, 1, 16'd300, 0, 16'd0, 0, 0, 32'd21));
    plan.push_back(snap(0, 0, 16'd0, 1, 16'd399, 0, 0, 32'd22));
    // gap equal to the period is still possible
    plan.push_back(snap(1, 1, 16'd60000, 1, 16'd0, 0, 0, 32'd23));
    send_plan();
    run_random(150);

    configure(17'd65536, 16'd0, 16'hFFFF);
    send_idle_pct = 50;
    run_random(150);

    configure(17'd2, 16'd0, 16'd1);
    send_idle_pct = 0;
    stall_pct <= 50;
    run_random(150);

    rp = $urandom_range(65536, 1000);
    rmin = $urandom_range(2000);
    rmax = $urandom_range(65535, rmin);
    configure(17'(rp), 16'(rmin), 16'(rmax));
    send_idle_pct = 24;
    stall_pct <= 24;
    run_random(150);

    // min above max: every echo is out of bounds
    configure(17'd40000, 16'hFFFF, 16'd0);
    send_idle_pct = 50;
    stall_pct <= 0;
    run_random(150);

    configure(uer_pkg::PeriodReset, uer_pkg::MinWidthReset, uer_pkg::MaxWidthReset);
    send_idle_pct = 0;
    run_random(150);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d snapshots over six settings (periods 2 to 65536, inverted bounds)",
             items_sent);
    $display("tb: %0d results checked: %0d ranged, %0d no echo, %0d bad",
             sb.n_ranged + sb.n_no_echo + sb.n_bad, sb.n_ranged, sb.n_no_echo, sb.n_bad);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
